// File: rtl/core/ffba_pkg.sv
// Shared types and constants for the first-fit block allocator.
// No dependencies; imported by ffba_cell, ffba_ctrl and the top level.
package ffba_pkg;

    localparam int LEN_W    = 11;
    localparam int OFF_W    = 10;
    localparam int STATUS_W = 3;
    localparam int CFG_W    = 11;

    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    // Entry flags: used, first, last
    typedef logic [2:0] flags_t;

    localparam flags_t FLAG_NONE  = 3'b000;
    localparam flags_t FLAG_USED  = 3'b001;
    localparam flags_t FLAG_FIRST = 3'b010;
    localparam flags_t FLAG_LAST  = 3'b100;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_ZERO     = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOMEM    = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_RANGE    = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_NOTFIRST = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_BROKEN   = 3'd5;

    // Control from the sequencer to the ring of cells
    typedef struct packed {
        logic   shift;
        flags_t wb;
    } ring_ctl_t;

endpackage

// File: rtl/core/ffba_cell.sv
// One table entry of the allocator ring: holds three flag bits and takes
// its neighbour's flags (the write-back at the tail) on every shift. Depends on ffba_pkg.
module ffba_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift,
    input  ffba_pkg::flags_t d,
    output ffba_pkg::flags_t q
);
    import ffba_pkg::*;

    flags_t flags_reg;
    flags_t flags_next;

    always_comb
    begin
        flags_next = shift ? d : flags_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= FLAG_NONE;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    assign q = flags_reg;

endmodule

// File: rtl/core/ffba_ctrl.sv
// Sequencer for the allocator: watches the head of the ring, runs the
// first-fit scan, the marking pass and the free walk, and holds the result.
// Depends on ffba_pkg.
module ffba_ctrl #(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          operation,
    input  logic [ffba_pkg::LEN_W-1:0]    request_length,
    input  logic [ffba_pkg::OFF_W-1:0]    free_offset,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ffba_pkg::OFF_W-1:0]    start_offset,
    output logic [ffba_pkg::STATUS_W-1:0] status,
    input  logic [$clog2(MAX_ENTRIES+1)-1:0] size,
    input  ffba_pkg::flags_t              head,
    output ffba_pkg::ring_ctl_t           ring_ctl
);
    import ffba_pkg::*;

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(MAX_ENTRIES - 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_MARK   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic                op_reg, op_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [OFF_W-1:0]    off_reg, off_next;
    logic [CNT_W-1:0]    size_reg, size_next;
    logic [IDX_W-1:0]    pos_reg, pos_next;
    logic [CNT_W-1:0]    run_reg, run_next;
    logic                found_reg, found_next;
    logic [IDX_W-1:0]    start_reg, start_next;
    logic [IDX_W-1:0]    end_reg, end_next;
    logic                walk_reg, walk_next;
    logic                decided_reg, decided_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [IDX_W-1:0]    res_start_reg, res_start_next;
    logic                out_valid_reg, out_valid_next;
    logic [OFF_W-1:0]    out_start_reg;
    logic [STATUS_W-1:0] out_status_reg;

    logic                load_out;
    logic                pass_end;
    logic                in_act;
    logic                walk_now;
    logic [CNT_W-1:0]    run_step;
    logic [31:0]         start_calc;
    logic [31:0]         res_wide;
    flags_t              wb;

    assign pass_end   = (pos_reg == LAST_POS);
    assign in_act     = (32'(pos_reg) < 32'(size_reg));
    assign start_calc = 32'(pos_reg) + 32'd1 - 32'(len_reg);
    assign res_wide   = 32'(res_start_reg);

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        len_next        = len_reg;
        off_next        = off_reg;
        size_next       = size_reg;
        pos_next        = pos_reg;
        run_next        = run_reg;
        found_next      = found_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        walk_next       = walk_reg;
        decided_next    = decided_reg;
        res_status_next = res_status_reg;
        res_start_next  = res_start_reg;
        load_out        = 1'b0;
        walk_now        = 1'b0;
        run_step        = '0;
        wb              = head;
        ring_ctl.shift  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next         = operation;
                    len_next        = request_length;
                    off_next        = free_offset;
                    size_next       = size;
                    pos_next        = '0;
                    run_next        = '0;
                    found_next      = 1'b0;
                    walk_next       = 1'b0;
                    decided_next    = 1'b0;
                    res_start_next  = '0;
                    res_status_next = STATUS_OK;
                    state_next      = ST_SCAN;
                    if (operation == OP_ALLOC)
                    begin
                        if (request_length == '0)
                        begin
                            res_status_next = STATUS_ZERO;
                            state_next      = ST_FINISH;
                        end
                    end
                    else if (32'(free_offset) >= 32'(size))
                    begin
                        res_status_next = STATUS_RANGE;
                        state_next      = ST_FINISH;
                    end
                end
            end

            ST_SCAN:
            begin
                ring_ctl.shift = 1'b1;
                pos_next       = pass_end ? '0 : pos_reg + 1'b1;
                if (op_reg == OP_ALLOC)
                begin
                    if (in_act && !found_reg)
                    begin
                        run_step = (head == FLAG_NONE) ? run_reg + 1'b1 : '0;
                        run_next = run_step;
                        if (32'(run_step) == 32'(len_reg))
                        begin
                            found_next = 1'b1;
                            end_next   = pos_reg;
                            start_next = start_calc[IDX_W-1:0];
                        end
                    end
                    if (pass_end)
                    begin
                        if (found_next)
                        begin
                            state_next = ST_MARK;
                        end
                        else
                        begin
                            res_status_next = STATUS_NOMEM;
                            state_next      = ST_FINISH;
                        end
                    end
                end
                else
                begin
                    if (in_act && !decided_reg)
                    begin
                        walk_now = walk_reg;
                        if (!walk_reg && (32'(pos_reg) == 32'(off_reg)))
                        begin
                            if ((head & FLAG_FIRST) == FLAG_NONE)
                            begin
                                decided_next    = 1'b1;
                                res_status_next = STATUS_NOTFIRST;
                            end
                            else
                            begin
                                walk_now = 1'b1;
                            end
                        end
                        if (walk_now)
                        begin
                            if ((head & FLAG_LAST) != FLAG_NONE)
                            begin
                                wb              = FLAG_NONE;
                                decided_next    = 1'b1;
                                res_status_next = STATUS_OK;
                            end
                            else if ((head & FLAG_USED) == FLAG_NONE)
                            begin
                                decided_next    = 1'b1;
                                res_status_next = STATUS_BROKEN;
                            end
                            else
                            begin
                                wb        = FLAG_NONE;
                                walk_next = 1'b1;
                            end
                        end
                    end
                    if (pass_end)
                    begin
                        // walk ran into the end of the active table
                        if (!decided_next)
                        begin
                            res_status_next = STATUS_BROKEN;
                        end
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_MARK:
            begin
                ring_ctl.shift = 1'b1;
                pos_next       = pass_end ? '0 : pos_reg + 1'b1;
                if ((pos_reg >= start_reg) && (pos_reg <= end_reg))
                begin
                    wb = FLAG_USED
                       | ((pos_reg == start_reg) ? FLAG_FIRST : FLAG_NONE)
                       | ((pos_reg == end_reg) ? FLAG_LAST : FLAG_NONE);
                end
                if (pass_end)
                begin
                    res_status_next = STATUS_OK;
                    res_start_next  = start_reg;
                    state_next      = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        ring_ctl.wb = wb;

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            found_reg     <= 1'b0;
            walk_reg      <= 1'b0;
            decided_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            found_reg     <= found_next;
            walk_reg      <= walk_next;
            decided_reg   <= decided_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        len_reg        <= len_next;
        off_reg        <= off_next;
        size_reg       <= size_next;
        run_reg        <= run_next;
        start_reg      <= start_next;
        end_reg        <= end_next;
        res_status_reg <= res_status_next;
        res_start_reg  <= res_start_next;
        if (load_out)
        begin
            out_start_reg  <= res_wide[OFF_W-1:0];
            out_status_reg <= res_status_reg;
        end
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign start_offset = out_start_reg;
    assign status       = out_status_reg;

    a_idle_pos_home: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (pos_reg == '0))
        else $error("ring not realigned on return to idle");

    a_mark_needs_find: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MARK) |-> found_reg)
        else $error("marking pass without a found run");

    a_mark_first: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_MARK) && (pos_reg == start_reg))
            |-> (ring_ctl.wb == (FLAG_USED | FLAG_FIRST)
                 || ring_ctl.wb == (FLAG_USED | FLAG_FIRST | FLAG_LAST)))
        else $error("run start not marked used and first");

    a_error_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FINISH) && (res_status_reg != STATUS_OK))
            |-> (res_start_reg == '0))
        else $error("non-zero start offset on error");

    a_hold_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) || (state_reg == ST_MARK)) |-> ring_ctl.shift)
        else $error("ring stalled during a pass");

endmodule

// File: rtl/core/first_fit_block_allocator.sv
// First-fit block allocator: a ring of MAX_ENTRIES flag cells rotates past one sequencer.
// Zero-length and out-of-range requests go straight to the result; free and failed
// allocate take one scan pass of the ring; successful allocate adds a marking pass.
// One item at a time; the ring rotation (one entry per cycle) sets the rate.
// Reset (rst_n, async, active low) clears every entry to free and cfg_reg to 1024.
module first_fit_block_allocator #(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          operation,
    input  logic [ffba_pkg::LEN_W-1:0]    request_length,
    input  logic [ffba_pkg::OFF_W-1:0]    free_offset,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ffba_pkg::OFF_W-1:0]    start_offset,
    output logic [ffba_pkg::STATUS_W-1:0] status,
    input  logic                          cfg_we,
    input  logic [ffba_pkg::CFG_W-1:0]    cfg_wdata
);
    import ffba_pkg::*;

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    logic [CFG_W-1:0] cfg_reg;
    logic [CFG_W-1:0] cfg_next;
    logic [CNT_W-1:0] size;
    ring_ctl_t        ring_ctl;
    flags_t           cell_q [MAX_ENTRIES];

    assign cfg_next = cfg_we ? cfg_wdata : cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // saturate the managed size at the table depth
    assign size = (32'(cfg_reg) > 32'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : CNT_W'(cfg_reg);

    for (genvar k = 0; k < MAX_ENTRIES; k++)
    begin : g_cell
        if (k == MAX_ENTRIES - 1)
        begin : g_tail
            ffba_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (ring_ctl.shift),
                .d     (ring_ctl.wb),
                .q     (cell_q[k])
            );
        end
        else
        begin : g_body
            ffba_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (ring_ctl.shift),
                .d     (cell_q[k+1]),
                .q     (cell_q[k])
            );
        end
    end

    ffba_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .request_length (request_length),
        .free_offset    (free_offset),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .start_offset   (start_offset),
        .status         (status),
        .size           (size),
        .head           (cell_q[0]),
        .ring_ctl       (ring_ctl)
    );

endmodule
